// ===== rtl/jtt_pkg.sv =====
// Shared codes and field widths for the deferred job timer table.
`timescale 1ns / 1ps
`default_nettype none

package jtt_pkg;

    localparam int KIND_W  = 2;
    localparam int DELAY_W = 40;
    localparam int TAG_W   = 16;
    localparam int STEP_W  = 20;
    localparam int STAT_W  = 2;
    localparam int PEND_W  = 5;

    localparam logic [STEP_W-1:0] STEP_RESET = 20'd1000;

    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SCHED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRE  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_NONE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/deferred_job_timer_table.sv =====
// Top level of the deferred job timer table: time counter, job count and scan sequencer.
//
// Usage: an item is taken at a rising edge with start high and busy low; i_kind selects
// tick (advance time by the tick step), schedule (append i_job_tag with i_delay_ns and the
// current time) or fire (remove the oldest due job and return its tag). Every item yields
// exactly one result, shown for one cycle with o_valid high, carrying o_status, o_due_tag
// and o_pending_count. The receiver cannot stall; results are never held.
// Tick, schedule, unused kinds and a fire on an empty table give the result in the cycle
// after the item and keep busy low, so such items may follow every cycle.
// A fire on a table holding N jobs scans entries one per cycle through the job store's
// registered read port up to the first due job, then moves later entries down one per
// cycle; busy stays high meanwhile, and the result is shown in the cycle busy returns low.
// The single read port of the job store is why a fire visits one entry at a time.
// Write the tick step register via i_cfg_we / i_cfg_wdata only while idle; not enforced.
// Reset clears the time, the job count, the sequencer and sets the tick step to 1000 ns;
// the job store needs no clearing, as only entries below the job count are read.
`timescale 1ns / 1ps
`default_nettype none

module deferred_job_timer_table #(
    parameter int TABLE_DEPTH = 16,
    parameter int TIME_WIDTH  = 48
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [jtt_pkg::STEP_W-1:0]   i_cfg_wdata,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [jtt_pkg::KIND_W-1:0]   i_kind,
    input  wire logic [jtt_pkg::DELAY_W-1:0]  i_delay_ns,
    input  wire logic [jtt_pkg::TAG_W-1:0]    i_job_tag,
    output logic                              o_valid,
    output logic      [jtt_pkg::STAT_W-1:0]   o_status,
    output logic      [jtt_pkg::TAG_W-1:0]    o_due_tag,
    output logic      [jtt_pkg::PEND_W-1:0]   o_pending_count
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int PW    = jtt_pkg::PEND_W;
    localparam int DW    = jtt_pkg::DELAY_W;
    localparam int CMP_W = (TIME_WIDTH > DW) ? TIME_WIDTH : DW;
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    logic [1:0]                  r_state, n_state;
    logic [jtt_pkg::STEP_W-1:0]  r_step;
    logic [TIME_WIDTH-1:0]       r_time, n_time;
    logic [CW-1:0]               r_count, n_count;
    logic [CW-1:0]               r_idx, n_idx;
    logic                        r_valid, n_valid;
    logic [jtt_pkg::STAT_W-1:0]  r_status, n_status;
    logic [jtt_pkg::TAG_W-1:0]   r_tag, n_tag;
    logic [PW-1:0]               r_pend, n_pend;

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [TIME_WIDTH-1:0]       mem_wstart;
    logic [DW-1:0]               mem_wdelay;
    logic [jtt_pkg::TAG_W-1:0]   mem_wtag;
    logic [AW-1:0]               mem_raddr;
    logic [TIME_WIDTH-1:0]       rd_start;
    logic [DW-1:0]               rd_delay;
    logic [jtt_pkg::TAG_W-1:0]   rd_tag;

    logic [CW-1:0]               idx_next;
    logic [TIME_WIDTH-1:0]       elapsed;
    logic                        is_due;
    logic                        is_last;
    logic [CW-1:0]               count_dec;

    jtt_mem #(
        .DEPTH  (TABLE_DEPTH),
        .TIME_W (TIME_WIDTH)
    ) u_mem (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (mem_waddr),
        .i_wstart (mem_wstart),
        .i_wdelay (mem_wdelay),
        .i_wtag   (mem_wtag),
        .i_raddr  (mem_raddr),
        .o_rstart (rd_start),
        .o_rdelay (rd_delay),
        .o_rtag   (rd_tag)
    );

    assign idx_next  = r_idx + CW'(1);
    assign elapsed   = r_time - rd_start;
    assign is_due    = CMP_W'(elapsed) >= CMP_W'(rd_delay);
    assign is_last   = (idx_next == r_count);
    assign count_dec = r_count - CW'(1);

    always_comb begin
        n_state    = r_state;
        n_time     = r_time;
        n_count    = r_count;
        n_idx      = r_idx;
        n_valid    = 1'b0;
        n_status   = r_status;
        n_tag      = r_tag;
        n_pend     = r_pend;
        mem_we     = 1'b0;
        mem_waddr  = AW'(r_idx - CW'(1));
        mem_wstart = rd_start;
        mem_wdelay = rd_delay;
        mem_wtag   = rd_tag;
        mem_raddr  = AW'(idx_next);

        unique case (r_state)
            S_IDLE: begin
                mem_raddr = '0;
                if (start) begin
                    n_valid  = 1'b1;
                    n_status = jtt_pkg::ST_OK;
                    n_tag    = '0;
                    n_pend   = PW'(r_count);
                    case (i_kind)
                        jtt_pkg::KIND_TICK: begin
                            n_time = r_time + TIME_WIDTH'(r_step);
                        end
                        jtt_pkg::KIND_SCHED: begin
                            if (r_count == FULL_COUNT) begin
                                n_status = jtt_pkg::ST_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                mem_waddr  = AW'(r_count);
                                mem_wstart = r_time;
                                mem_wdelay = i_delay_ns;
                                mem_wtag   = i_job_tag;
                                n_count    = r_count + CW'(1);
                                n_pend     = PW'(r_count + CW'(1));
                            end
                        end
                        jtt_pkg::KIND_FIRE: begin
                            if (r_count == '0) begin
                                n_status = jtt_pkg::ST_NONE;
                            end else begin
                                n_valid = 1'b0;
                                n_state = S_SCAN;
                                n_idx   = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (is_due) begin
                    n_tag = rd_tag;
                    if (is_last) begin
                        n_valid  = 1'b1;
                        n_status = jtt_pkg::ST_OK;
                        n_count  = count_dec;
                        n_pend   = PW'(count_dec);
                        n_state  = S_IDLE;
                    end else begin
                        n_idx   = idx_next;
                        n_state = S_SHIFT;
                    end
                end else if (is_last) begin
                    n_valid  = 1'b1;
                    n_status = jtt_pkg::ST_NONE;
                    n_tag    = '0;
                    n_pend   = PW'(r_count);
                    n_state  = S_IDLE;
                end else begin
                    n_idx = idx_next;
                end
            end
            S_SHIFT: begin
                mem_we = 1'b1;
                if (is_last) begin
                    n_valid  = 1'b1;
                    n_status = jtt_pkg::ST_OK;
                    n_count  = count_dec;
                    n_pend   = PW'(count_dec);
                    n_state  = S_IDLE;
                end else begin
                    n_idx = idx_next;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= jtt_pkg::STEP_RESET;
            r_time  <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_time  <= n_time;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_step <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_tag    <= n_tag;
        r_pend   <= n_pend;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_due_tag       = r_tag;
    assign o_pending_count = r_pend;

endmodule

`default_nettype wire

// ===== rtl/jtt_mem.sv =====
// Job store: start time, delay and tag per entry, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module jtt_mem #(
    parameter int DEPTH  = 16,
    parameter int TIME_W = 48
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [$clog2(DEPTH)-1:0]      i_waddr,
    input  wire logic [TIME_W-1:0]             i_wstart,
    input  wire logic [jtt_pkg::DELAY_W-1:0]   i_wdelay,
    input  wire logic [jtt_pkg::TAG_W-1:0]     i_wtag,
    input  wire logic [$clog2(DEPTH)-1:0]      i_raddr,
    output logic      [TIME_W-1:0]             o_rstart,
    output logic      [jtt_pkg::DELAY_W-1:0]   o_rdelay,
    output logic      [jtt_pkg::TAG_W-1:0]     o_rtag
);

    logic [TIME_W-1:0]           r_start [DEPTH];
    logic [jtt_pkg::DELAY_W-1:0] r_delay [DEPTH];
    logic [jtt_pkg::TAG_W-1:0]   r_tag   [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_start[i_waddr] <= i_wstart;
            r_delay[i_waddr] <= i_wdelay;
            r_tag[i_waddr]   <= i_wtag;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rstart <= r_start[i_raddr];
        o_rdelay <= r_delay[i_raddr];
        o_rtag   <= r_tag[i_raddr];
    end

endmodule

`default_nettype wire

// ===== dv/jtt_table_monitor.sv =====
// Monitor for the deferred job timer table: tracks the job table, predicts each result and compares.
`timescale 1ns / 1ps

module jtt_table_monitor #(
    parameter int TABLE_DEPTH = 16,
    parameter int TIME_WIDTH  = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [jtt_pkg::STEP_W-1:0]    i_cfg_wdata,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic [jtt_pkg::KIND_W-1:0]    i_kind,
    input  logic [jtt_pkg::DELAY_W-1:0]   i_delay_ns,
    input  logic [jtt_pkg::TAG_W-1:0]     i_job_tag,
    input  logic                          i_valid,
    input  logic [jtt_pkg::STAT_W-1:0]    i_status,
    input  logic [jtt_pkg::TAG_W-1:0]     i_due_tag,
    input  logic [jtt_pkg::PEND_W-1:0]    i_pending_count,
    output int                            o_errors,
    output int                            o_waiting,
    output int                            o_items,
    output int                            o_removed,
    output int                            o_nothing_due,
    output int                            o_refused
);

    typedef struct packed {
        logic [jtt_pkg::STAT_W-1:0] status;
        logic [jtt_pkg::TAG_W-1:0]  tag;
        logic [jtt_pkg::PEND_W-1:0] pending;
    } t_outcome;

    logic [jtt_pkg::STEP_W-1:0]  step_ns;
    logic [TIME_WIDTH-1:0]       now_ns;
    int unsigned                 held;
    logic [TIME_WIDTH-1:0]       start_ns [TABLE_DEPTH];
    logic [jtt_pkg::DELAY_W-1:0] wait_ns  [TABLE_DEPTH];
    logic [jtt_pkg::TAG_W-1:0]   tag_of   [TABLE_DEPTH];
    t_outcome                    outcome_q [$];
    int                          err_cnt = 0;
    int                          n_pred  = 0;
    int                          n_seen  = 0;

    assign o_errors  = err_cnt;
    assign o_waiting = n_pred - n_seen;

    task automatic report(input string what, input longint unsigned got,
                          input longint unsigned want);
        $display("%0t mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        err_cnt++;
    endtask

    function automatic t_outcome run_table_item(input logic [jtt_pkg::KIND_W-1:0]  kind,
                                                input logic [jtt_pkg::DELAY_W-1:0] delay_ns,
                                                input logic [jtt_pkg::TAG_W-1:0]   tag);
        t_outcome              res;
        logic [TIME_WIDTH-1:0] age;
        bit                    found;
        res   = '0;
        found = 1'b0;
        case (kind)
            jtt_pkg::KIND_TICK: now_ns = now_ns + TIME_WIDTH'(step_ns);
            jtt_pkg::KIND_SCHED: begin
                if (held >= TABLE_DEPTH) begin
                    res.status = jtt_pkg::ST_FULL;
                end else begin
                    start_ns[held] = now_ns;
                    wait_ns[held]  = delay_ns;
                    tag_of[held]   = tag;
                    held++;
                end
            end
            jtt_pkg::KIND_FIRE: begin
                res.status = jtt_pkg::ST_NONE;
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (!found && i < held) begin
                        age = now_ns - start_ns[i];
                        if (age >= wait_ns[i]) begin
                            found      = 1'b1;
                            res.status = jtt_pkg::ST_OK;
                            res.tag    = tag_of[i];
                            for (int j = i; j + 1 < held; j++) begin
                                start_ns[j] = start_ns[j+1];
                                wait_ns[j]  = wait_ns[j+1];
                                tag_of[j]   = tag_of[j+1];
                            end
                            held--;
                        end
                    end
                end
            end
            default: ;
        endcase
        res.pending = held[jtt_pkg::PEND_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        if (!i_rst_n) begin
            step_ns = jtt_pkg::STEP_RESET;
            now_ns  = '0;
            held    = 0;
            outcome_q.delete();
            n_pred        <= 0;
            n_seen        <= 0;
            o_items       <= 0;
            o_removed     <= 0;
            o_nothing_due <= 0;
            o_refused     <= 0;
        end else begin
            if (i_valid) begin
                got = '{i_status, i_due_tag, i_pending_count};
                if (outcome_q.size() == 0) begin
                    report("result with no item outstanding", got, '0);
                end else begin
                    want = outcome_q.pop_front();
                    if (got.status != want.status)
                        report("status", got.status, want.status);
                    if (got.tag != want.tag)
                        report("due_tag", got.tag, want.tag);
                    if (got.pending != want.pending)
                        report("pending_count", got.pending, want.pending);
                    n_seen <= n_seen + 1;
                end
            end
            if (i_cfg_we)
                step_ns = i_cfg_wdata;
            if (i_start && !i_busy) begin
                want = run_table_item(i_kind, i_delay_ns, i_job_tag);
                outcome_q.push_back(want);
                n_pred  <= n_pred + 1;
                o_items <= o_items + 1;
                if (i_kind == jtt_pkg::KIND_FIRE && want.status == jtt_pkg::ST_OK)
                    o_removed <= o_removed + 1;
                if (want.status == jtt_pkg::ST_NONE)
                    o_nothing_due <= o_nothing_due + 1;
                if (want.status == jtt_pkg::ST_FULL)
                    o_refused <= o_refused + 1;
            end
        end
    end

endmodule

// ===== dv/deferred_job_timer_table_tb.sv =====
// Testbench top for the deferred job timer table: clock, reset, item stimulus and verdict.
`timescale 1ns / 1ps

module deferred_job_timer_table_tb;

    localparam int TABLE_DEPTH = 16;
    localparam int TIME_WIDTH  = 48;
    localparam int QUIET_LIMIT = 2000;
    localparam int N_PHASES    = 7;
    localparam int PHASE_ITEMS = 118;

    localparam int KIND_W  = jtt_pkg::KIND_W;
    localparam int DELAY_W = jtt_pkg::DELAY_W;
    localparam int TAG_W   = jtt_pkg::TAG_W;
    localparam int STEP_W  = jtt_pkg::STEP_W;
    localparam int STAT_W  = jtt_pkg::STAT_W;
    localparam int PEND_W  = jtt_pkg::PEND_W;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [STEP_W-1:0]  i_cfg_wdata = '0;
    logic               start       = 1'b0;
    logic               busy;
    logic [KIND_W-1:0]  i_kind      = jtt_pkg::KIND_TICK;
    logic [DELAY_W-1:0] i_delay_ns  = '0;
    logic [TAG_W-1:0]   i_job_tag   = '0;
    logic               o_valid;
    logic [STAT_W-1:0]  o_status;
    logic [TAG_W-1:0]   o_due_tag;
    logic [PEND_W-1:0]  o_pending_count;

    int n_errors;
    int n_waiting;
    int n_items;
    int n_removed;
    int n_nothing_due;
    int n_refused;
    bit steady = 1'b0;

    deferred_job_timer_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_delay_ns      (i_delay_ns),
        .i_job_tag       (i_job_tag),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_due_tag       (o_due_tag),
        .o_pending_count (o_pending_count)
    );

    jtt_table_monitor #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_monitor (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_start         (start),
        .i_busy          (busy),
        .i_kind          (i_kind),
        .i_delay_ns      (i_delay_ns),
        .i_job_tag       (i_job_tag),
        .i_valid         (o_valid),
        .i_status        (o_status),
        .i_due_tag       (o_due_tag),
        .i_pending_count (o_pending_count),
        .o_errors        (n_errors),
        .o_waiting       (n_waiting),
        .o_items         (n_items),
        .o_removed       (n_removed),
        .o_nothing_due   (n_nothing_due),
        .o_refused       (n_refused)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_item(input logic [KIND_W-1:0]  kind,
                             input logic [DELAY_W-1:0] delay_ns,
                             input logic [TAG_W-1:0]   tag);
        if (!steady && $urandom_range(99) < 8) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_kind     <= kind;
        i_delay_ns <= delay_ns;
        i_job_tag  <= tag;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (n_waiting != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_step(input logic [STEP_W-1:0] value);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_item(input int sched_pct, input logic [STEP_W-1:0] step_ns);
        int                 roll;
        logic [KIND_W-1:0]  kind;
        logic [DELAY_W-1:0] delay_ns;
        logic [63:0]        wide;
        roll = $urandom_range(99);
        if (roll < 4)
            kind = KIND_UNUSED;
        else if (roll < 4 + sched_pct)
            kind = jtt_pkg::KIND_SCHED;
        else if (roll < 4 + sched_pct + (96 - sched_pct) / 2)
            kind = jtt_pkg::KIND_TICK;
        else
            kind = jtt_pkg::KIND_FIRE;
        wide = {$urandom(), $urandom()};
        case ($urandom_range(9))
            0, 1:    delay_ns = wide[DELAY_W-1:0];
            2, 3, 4: delay_ns = DELAY_W'($urandom_range(0, 3000));
            default: delay_ns = DELAY_W'($urandom_range(0, 12)) * DELAY_W'(step_ns)
                                + DELAY_W'($urandom_range(0, step_ns));
        endcase
        send_item(kind, delay_ns, TAG_W'($urandom_range(0, 65535)));
    endtask

    initial begin
        int                quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_valid)
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        logic [STEP_W-1:0] phase_step  [N_PHASES];
        int                phase_sched [N_PHASES];
        phase_step  = '{20'hFFFFF, 20'd0, 20'd1, 20'd1000000, 20'd0, 20'd0,
                        jtt_pkg::STEP_RESET};
        phase_sched = '{35, 45, 30, 55, 40, 35, 50};
        phase_step[4] = STEP_W'($urandom_range(1, 1000000));
        phase_step[5] = STEP_W'($urandom_range(1, 5000));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(jtt_pkg::KIND_FIRE, '0, '0);
        send_item(KIND_UNUSED, '1, '1);
        send_item(jtt_pkg::KIND_SCHED, '0, 16'hFFFF);
        send_item(jtt_pkg::KIND_SCHED, '1, 16'h0000);
        send_item(jtt_pkg::KIND_SCHED, 40'd2000, 16'h1234);
        send_item(jtt_pkg::KIND_FIRE, '1, '1);
        send_item(jtt_pkg::KIND_FIRE, '0, '0);
        send_item(jtt_pkg::KIND_TICK, '1, '1);
        send_item(jtt_pkg::KIND_TICK, '0, '0);
        send_item(jtt_pkg::KIND_FIRE, '0, '0);
        send_item(jtt_pkg::KIND_FIRE, '0, '0);
        for (int i = 0; i < TABLE_DEPTH - 1; i++)
            send_item(jtt_pkg::KIND_SCHED, '0, 16'hA000 + TAG_W'(i));
        send_item(jtt_pkg::KIND_SCHED, '0, 16'hBEEF);
        send_item(jtt_pkg::KIND_FIRE, '0, '0);

        for (int p = 0; p < N_PHASES; p++) begin
            write_step(phase_step[p]);
            steady = (p == 2);
            repeat (PHASE_ITEMS) random_item(phase_sched[p], phase_step[p]);
        end
        steady = 1'b0;

        settle();
        repeat (20) @(posedge i_clk);

        $display("Ran %0d items across %0d tick step settings, zero and all ones included.",
                 n_items, N_PHASES + 1);
        $display("Due jobs removed: %0d, fires with nothing due: %0d, schedules refused: %0d.",
                 n_removed, n_nothing_due, n_refused);
        if (n_errors == 0 && n_waiting == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== deferred_job_timer_table.f =====
rtl/jtt_pkg.sv
rtl/jtt_mem.sv
rtl/deferred_job_timer_table.sv
dv/jtt_table_monitor.sv
dv/deferred_job_timer_table_tb.sv
